/* rtl/bilinear_image_scaler_assert.svh */
// Assertion macros shared by the scaler RTL.
// No dependencies; each macro samples on i_clk and is off during reset.
`ifndef BILINEAR_IMAGE_SCALER_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_ASSERT_SVH

// Overlapping implication.
`define BIS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("bilinear scaler assertion failed");

// Implication checked in the next cycle.
`define BIS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bilinear scaler assertion failed");

`endif

/* rtl/bis_pkg.sv */
// Shared constants and types of the bilinear image scaler.
// No dependencies.
package bis_pkg;
    localparam int PERCENT       = 100;
    localparam int NUM_BANKS     = 4;
    localparam int MAX_W_DEFAULT = 1024;
    localparam int MAX_H_DEFAULT = 1024;
    localparam int WB_DEFAULT    = 8;
    localparam int POS_W         = 12;
    localparam int CLR_W         = 8;
    localparam int PIX_W         = 3 * CLR_W;
    localparam int CFG_W         = 11;
    localparam int SCALE_W       = 9;
    // Width of pos * PERCENT for the widest position.
    localparam int NUM_W         = 19;

    localparam logic [CFG_W-1:0]   RST_SRC_W = 11'd1024;
    localparam logic [CFG_W-1:0]   RST_SRC_H = 11'd1024;
    localparam logic [SCALE_W-1:0] RST_SCALE = 9'd100;

    typedef enum logic [1:0] {
        CFG_SRC_W = 2'd0,
        CFG_SRC_H = 2'd1,
        CFG_SCALE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;
endpackage

/* rtl/bis_div.sv */
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// Depends on bis_pkg. Carries a side tag alongside the quotients.
module bis_div
    import bis_pkg::*;
#(
    parameter int DW = NUM_W + WB_DEFAULT,
    parameter int TW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [DW-1:0]      i_num_x,
    input  logic [DW-1:0]      i_num_y,
    input  logic [SCALE_W-1:0] i_den,
    input  logic [TW-1:0]      i_tag,
    output logic               o_valid,
    output logic [DW-1:0]      o_q_x,
    output logic [DW-1:0]      o_q_y,
    output logic [TW-1:0]      o_tag
);
    logic               r_v   [DW];
    logic [TW-1:0]      r_tag [DW];
    logic [DW-1:0]      r_qx  [DW];
    logic [DW-1:0]      r_qy  [DW];
    logic [SCALE_W-1:0] r_rx  [DW];
    logic [SCALE_W-1:0] r_ry  [DW];
    logic [DW-1:0]      n_qx  [DW];
    logic [DW-1:0]      n_qy  [DW];
    logic [SCALE_W-1:0] n_rx  [DW];
    logic [SCALE_W-1:0] n_ry  [DW];

    // Each stage shifts one dividend bit into the partial remainder.
    always_comb begin
        logic [DW-1:0]      qx;
        logic [DW-1:0]      qy;
        logic [SCALE_W-1:0] rx;
        logic [SCALE_W-1:0] ry;
        logic [SCALE_W:0]   tx;
        logic [SCALE_W:0]   ty;
        for (int k = 0; k < DW; k++) begin
            if (k == 0) begin
                qx = i_num_x;
                qy = i_num_y;
                rx = '0;
                ry = '0;
            end else begin
                qx = r_qx[k-1];
                qy = r_qy[k-1];
                rx = r_rx[k-1];
                ry = r_ry[k-1];
            end
            tx = {rx, qx[DW-1]};
            ty = {ry, qy[DW-1]};
            if (tx >= {1'b0, i_den}) begin
                tx = tx - {1'b0, i_den};
                n_qx[k] = {qx[DW-2:0], 1'b1};
            end else begin
                n_qx[k] = {qx[DW-2:0], 1'b0};
            end
            if (ty >= {1'b0, i_den}) begin
                ty = ty - {1'b0, i_den};
                n_qy[k] = {qy[DW-2:0], 1'b1};
            end else begin
                n_qy[k] = {qy[DW-2:0], 1'b0};
            end
            n_rx[k] = tx[SCALE_W-1:0];
            n_ry[k] = ty[SCALE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DW; k++) begin
            r_qx[k]  <= n_qx[k];
            r_qy[k]  <= n_qy[k];
            r_rx[k]  <= n_rx[k];
            r_ry[k]  <= n_ry[k];
            r_tag[k] <= (k == 0) ? i_tag : r_tag[k-1];
        end
        if (!i_rst_n) begin
            for (int k = 0; k < DW; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < DW; k++) begin
                r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
            end
        end
    end

    assign o_valid = r_v[DW-1];
    assign o_q_x   = r_qx[DW-1];
    assign o_q_y   = r_qy[DW-1];
    assign o_tag   = r_tag[DW-1];
endmodule

/* rtl/bis_store.sv */
// Source frame store: four banks split by column and row parity, so the four
// neighbours of a position come out in one read. Depends on bis_pkg.
module bis_store
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_W_DEFAULT,
    parameter int MAX_HEIGHT = MAX_H_DEFAULT
) (
    input  logic                          i_clk,
    input  t_mem_ctl                      i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_x,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_y,
    input  logic [PIX_W-1:0]              i_wdata,
    output logic [PIX_W-1:0]              o_p00,
    output logic [PIX_W-1:0]              o_p10,
    output logic [PIX_W-1:0]              o_p01,
    output logic [PIX_W-1:0]              o_p11
);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int XHW   = (XW > 1) ? XW - 1 : 1;
    localparam int YHW   = (YW > 1) ? YW - 1 : 1;
    localparam int AW    = XHW + YHW;
    localparam int DEPTH = 2 ** AW;

    logic [XW:0]        w_x1;
    logic [YW:0]        w_y1;
    logic [XHW-1:0]     w_xh0;
    logic [XHW-1:0]     w_xh1;
    logic [YHW-1:0]     w_yh0;
    logic [YHW-1:0]     w_yh1;
    logic [PIX_W-1:0]   w_q [NUM_BANKS];
    logic               r_sx;
    logic               r_sy;

    assign w_x1  = (XW + 1)'(i_x) + 1'b1;
    assign w_y1  = (YW + 1)'(i_y) + 1'b1;
    assign w_xh0 = XHW'({1'b0, i_x} >> 1);
    assign w_xh1 = XHW'(w_x1 >> 1);
    assign w_yh0 = YHW'({1'b0, i_y} >> 1);
    assign w_yh1 = YHW'(w_y1 >> 1);

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        localparam logic BX = b[0];
        localparam logic BY = b[1];
        logic [PIX_W-1:0] mem [DEPTH];
        logic [PIX_W-1:0] r_q;
        logic [AW-1:0]    w_raddr;

        // A bank of the other parity holds the neighbour one step on.
        assign w_raddr = {(i_y[0] == BY) ? w_yh0 : w_yh1,
                          (i_x[0] == BX) ? w_xh0 : w_xh1};

        always_ff @(posedge i_clk) begin
            if (i_ctl.wr && i_x[0] == BX && i_y[0] == BY) begin
                mem[{w_yh0, w_xh0}] <= i_wdata;
            end
            if (i_ctl.rd) begin
                r_q <= mem[w_raddr];
            end
        end
        assign w_q[b] = r_q;
    end

    always_ff @(posedge i_clk) begin
        r_sx <= i_x[0];
        r_sy <= i_y[0];
    end

    assign o_p00 = w_q[{r_sy, r_sx}];
    assign o_p10 = w_q[{r_sy, ~r_sx}];
    assign o_p01 = w_q[{~r_sy, r_sx}];
    assign o_p11 = w_q[{~r_sy, ~r_sx}];
endmodule

/* rtl/bis_blend.sv */
// Edge replication and two-stage bilinear weighting of three channels.
// Depends on bis_pkg.
module bis_blend
    import bis_pkg::*;
#(
    parameter int WEIGHT_BITS = WB_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_ok,
    input  logic                   i_status,
    input  logic                   i_rx,
    input  logic                   i_ry,
    input  logic [WEIGHT_BITS-1:0] i_fx,
    input  logic [WEIGHT_BITS-1:0] i_fy,
    input  logic [PIX_W-1:0]       i_p00,
    input  logic [PIX_W-1:0]       i_p10,
    input  logic [PIX_W-1:0]       i_p01,
    input  logic [PIX_W-1:0]       i_p11,
    output logic                   o_strobe,
    output logic [CLR_W-1:0]       o_blue,
    output logic [CLR_W-1:0]       o_green,
    output logic [CLR_W-1:0]       o_red,
    output logic                   o_status
);
    localparam int WB = WEIGHT_BITS;
    localparam int HW = CLR_W + WB;
    localparam int SW = CLR_W + 2 * WB + 1;
    localparam logic [WB:0] ONE = (WB + 1)'(1) << WB;

    logic [PIX_W-1:0] w_p0, w_p1, w_p2, w_p3;
    logic [WB:0]      w_gx;
    logic [HW-1:0]    n_top [3];
    logic [HW-1:0]    n_bot [3];
    logic [HW-1:0]    r_top [3];
    logic [HW-1:0]    r_bot [3];
    logic [WB-1:0]    r_fy;
    logic             r_v, r_ok, r_st;
    logic [CLR_W-1:0] n_c [3];

    assign w_p0 = i_p00;
    assign w_p1 = i_rx ? i_p10 : w_p0;
    assign w_p3 = i_ry ? i_p01 : w_p0;
    assign w_p2 = (i_rx && i_ry) ? i_p11 : (!i_rx ? w_p3 : w_p1);
    assign w_gx = ONE - (WB + 1)'(i_fx);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_top[c] = HW'(w_p0[c*CLR_W +: CLR_W] * w_gx)
                     + HW'(w_p1[c*CLR_W +: CLR_W] * i_fx);
            n_bot[c] = HW'(w_p3[c*CLR_W +: CLR_W] * w_gx)
                     + HW'(w_p2[c*CLR_W +: CLR_W] * i_fx);
        end
    end

    always_comb begin
        logic [WB:0]   gy;
        logic [SW-1:0] sum;
        gy = ONE - (WB + 1)'(r_fy);
        for (int c = 0; c < 3; c++) begin
            sum = SW'(r_top[c] * gy) + SW'(r_bot[c] * r_fy);
            n_c[c] = r_ok ? sum[2*WB +: CLR_W] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_top[c] <= n_top[c];
            r_bot[c] <= n_bot[c];
        end
        r_fy     <= i_fy;
        r_ok     <= i_ok;
        r_st     <= i_status;
        o_blue   <= n_c[0];
        o_green  <= n_c[1];
        o_red    <= n_c[2];
        o_status <= r_st;
        if (!i_rst_n) begin
            r_v      <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_v      <= i_valid;
            o_strobe <= r_v;
        end
    end
endmodule

/* rtl/bilinear_image_scaler.sv */
// Bilinear image scaler over a four-bank source frame store.
// Command channel: an item is taken at each edge where start is high and
// busy is low; busy stays low, so one item enters every cycle.
// cmd 0 writes one source pixel, cmd 1 asks for one scaled pixel.
// Every item gives exactly one result, shown on the o_out_* and o_status
// ports for one cycle with o_strobe high, after the input register, the
// divider stages, the store read and the blend stages. The divider produces
// one quotient bit per stage; throughput is one item per clock. Writes and
// reads reach the store in item order, so a request always sees every
// earlier write.
// Configuration: a separate write port with i_cfg_valid, o_cfg_ready (always
// high), i_cfg_index and i_cfg_data. Write it only while the block is idle.
// Synchronous reset loads width 1024, height 1024, scale 100 and empties the
// pipeline; the frame store holds no defined data until written.
// The receiver cannot stall: results are never held back.
module bilinear_image_scaler
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_W_DEFAULT,
    parameter int MAX_HEIGHT  = MAX_H_DEFAULT,
    parameter int WEIGHT_BITS = WB_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic [POS_W-1:0]   i_pos_x,
    input  logic [POS_W-1:0]   i_pos_y,
    input  logic [CLR_W-1:0]   i_in_blue,
    input  logic [CLR_W-1:0]   i_in_green,
    input  logic [CLR_W-1:0]   i_in_red,
    output logic               o_strobe,
    output logic [CLR_W-1:0]   o_out_blue,
    output logic [CLR_W-1:0]   o_out_green,
    output logic [CLR_W-1:0]   o_out_red,
    output logic               o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);
`include "bilinear_image_scaler_assert.svh"

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int EW  = $clog2(MAX_WIDTH + 1);
    localparam int EH  = $clog2(MAX_HEIGHT + 1);
    localparam int WB  = WEIGHT_BITS;
    localparam int DW  = NUM_W + WB;
    localparam int PW  = ((EW > EH) ? EW : EH) + SCALE_W;
    localparam int TW  = 2 + XW + YW + PIX_W;
    localparam int LAT = DW + 4;

    logic [CFG_W-1:0]   r_src_w, r_src_h;
    logic [SCALE_W-1:0] r_scale;
    logic [EW-1:0]      w_w_eff;
    logic [EH-1:0]      w_h_eff;
    logic [SCALE_W-1:0] w_s_eff;
    logic [PW-1:0]      r_ws, r_hs;

    logic               r_s0_v, r_s0_cmd, r_s0_werr;
    logic [NUM_W-1:0]   r_s0_nx, r_s0_ny;
    logic [XW-1:0]      r_s0_px;
    logic [YW-1:0]      r_s0_py;
    logic [PIX_W-1:0]   r_s0_clr;
    logic               w_s0_err;
    logic [TW-1:0]      w_tag_in, w_tag_out;

    logic               w_d_v;
    logic [DW-1:0]      w_qx, w_qy;
    logic               w_d_cmd, w_d_err, w_err2, w_rx, w_ry;
    logic [XW-1:0]      w_d_px;
    logic [YW-1:0]      w_d_py;
    logic [PIX_W-1:0]   w_d_clr;
    logic [NUM_W-1:0]   w_i, w_j;
    t_mem_ctl           w_ctl;

    logic               r_m_v, r_m_ok, r_m_st, r_m_rx, r_m_ry;
    logic [WB-1:0]      r_m_fx, r_m_fy;
    logic [PIX_W-1:0]   w_p00, w_p10, w_p01, w_p11;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_SRC_W;
            r_src_h <= RST_SRC_H;
            r_scale <= RST_SCALE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SRC_W: r_src_w <= i_cfg_data;
                CFG_SRC_H: r_src_h <= i_cfg_data;
                CFG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturated sizes follow the registers at once; the scaled extents are
    // registered and are first needed in the cycle after an item is accepted.
    always_comb begin
        if (r_src_w == '0) begin
            w_w_eff = EW'(1);
        end else if ({1'b0, r_src_w} > (CFG_W + 1)'(MAX_WIDTH)) begin
            w_w_eff = EW'(MAX_WIDTH);
        end else begin
            w_w_eff = EW'(r_src_w);
        end
        if (r_src_h == '0) begin
            w_h_eff = EH'(1);
        end else if ({1'b0, r_src_h} > (CFG_W + 1)'(MAX_HEIGHT)) begin
            w_h_eff = EH'(MAX_HEIGHT);
        end else begin
            w_h_eff = EH'(r_src_h);
        end
        w_s_eff = (r_scale == '0) ? SCALE_W'(1) : r_scale;
    end

    always_ff @(posedge i_clk) begin
        r_ws <= PW'(w_w_eff) * PW'(w_s_eff);
        r_hs <= PW'(w_h_eff) * PW'(w_s_eff);
    end

    always_ff @(posedge i_clk) begin
        r_s0_cmd  <= i_cmd;
        r_s0_nx   <= NUM_W'(i_pos_x) * NUM_W'(PERCENT);
        r_s0_ny   <= NUM_W'(i_pos_y) * NUM_W'(PERCENT);
        r_s0_werr <= ((POS_W + EW)'(i_pos_x) >= (POS_W + EW)'(w_w_eff))
                  || ((POS_W + EH)'(i_pos_y) >= (POS_W + EH)'(w_h_eff));
        r_s0_px   <= XW'(i_pos_x);
        r_s0_py   <= YW'(i_pos_y);
        r_s0_clr  <= {i_in_red, i_in_green, i_in_blue};
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else begin
            r_s0_v <= start && !busy;
        end
    end

    // A request lies outside the scaled image when pos * 100 >= size * scale.
    assign w_s0_err = r_s0_cmd
        ? (((NUM_W + PW)'(r_s0_nx) >= (NUM_W + PW)'(r_ws))
        || ((NUM_W + PW)'(r_s0_ny) >= (NUM_W + PW)'(r_hs)))
        : r_s0_werr;
    assign w_tag_in = {r_s0_cmd, w_s0_err, r_s0_px, r_s0_py, r_s0_clr};

    // The quotient of (pos * 100) << WB by the scale holds the source index
    // above the weight bits and the interpolation weight in them.
    bis_div #(
        .DW (DW),
        .TW (TW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_v),
        .i_num_x ({r_s0_nx, {WB{1'b0}}}),
        .i_num_y ({r_s0_ny, {WB{1'b0}}}),
        .i_den   (w_s_eff),
        .i_tag   (w_tag_in),
        .o_valid (w_d_v),
        .o_q_x   (w_qx),
        .o_q_y   (w_qy),
        .o_tag   (w_tag_out)
    );

    assign {w_d_cmd, w_d_err, w_d_px, w_d_py, w_d_clr} = w_tag_out;
    assign w_i    = w_qx[DW-1:WB];
    assign w_j    = w_qy[DW-1:WB];
    assign w_err2 = w_d_err || (w_d_cmd
        && (((NUM_W + EW)'(w_i) >= (NUM_W + EW)'(w_w_eff))
        || ((NUM_W + EH)'(w_j) >= (NUM_W + EH)'(w_h_eff))));
    assign w_rx   = ((NUM_W + EW + 1)'(w_i) + 1'b1) < (NUM_W + EW + 1)'(w_w_eff);
    assign w_ry   = ((NUM_W + EH + 1)'(w_j) + 1'b1) < (NUM_W + EH + 1)'(w_h_eff);

    assign w_ctl.rd = w_d_v && w_d_cmd && !w_err2;
    assign w_ctl.wr = w_d_v && !w_d_cmd && !w_d_err;

    bis_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_x     (w_d_cmd ? XW'(w_i) : w_d_px),
        .i_y     (w_d_cmd ? YW'(w_j) : w_d_py),
        .i_wdata (w_d_clr),
        .o_p00   (w_p00),
        .o_p10   (w_p10),
        .o_p01   (w_p01),
        .o_p11   (w_p11)
    );

    always_ff @(posedge i_clk) begin
        r_m_ok <= w_d_cmd && !w_err2;
        r_m_st <= w_err2;
        r_m_rx <= w_rx;
        r_m_ry <= w_ry;
        r_m_fx <= w_qx[WB-1:0];
        r_m_fy <= w_qy[WB-1:0];
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else begin
            r_m_v <= w_d_v;
        end
    end

    bis_blend #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_m_v),
        .i_ok     (r_m_ok),
        .i_status (r_m_st),
        .i_rx     (r_m_rx),
        .i_ry     (r_m_ry),
        .i_fx     (r_m_fx),
        .i_fy     (r_m_fy),
        .i_p00    (w_p00),
        .i_p10    (w_p10),
        .i_p01    (w_p01),
        .i_p11    (w_p11),
        .o_strobe (o_strobe),
        .o_blue   (o_out_blue),
        .o_green  (o_out_green),
        .o_red    (o_out_red),
        .o_status (o_status)
    );

    `BIS_ASSERT_IMPL(a_fixed_latency, start && !busy, ##LAT o_strobe)
    `BIS_ASSERT_IMPL(a_error_is_black, o_strobe && o_status, (o_out_blue | o_out_green | o_out_red) == '0)
    `BIS_ASSERT_NEXT(a_scale_write, i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_SCALE, r_scale == $past(i_cfg_data[SCALE_W-1:0]))
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for bilinear_image_scaler: pixel writes and scaled requests
// under several size and scale settings, checked against an in-bench pixel predictor.
// Depends on bis_pkg and the bilinear_image_scaler RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bis_pkg::*;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       status;
    } t_pixel_res;

    class pixel_scoreboard;
        logic [23:0]     store [int];
        int unsigned     src_w;
        int unsigned     src_h;
        int unsigned     scale;
        t_pixel_res      expected_q [$];
        int              errors;
        int              n_reads;
        int              n_errs;

        function void reset_state();
            src_w = RST_SRC_W;
            src_h = RST_SRC_H;
            scale = RST_SCALE;
            store.delete();
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_SRC_W: src_w = data;
                CFG_SRC_H: src_h = data;
                CFG_SCALE: scale = data[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_w();
            return src_w < 1 ? 1 : (src_w > 1024 ? 1024 : src_w);
        endfunction

        function int unsigned eff_h();
            return src_h < 1 ? 1 : (src_h > 1024 ? 1024 : src_h);
        endfunction

        function logic [23:0] fetch(int unsigned x, int unsigned y, inout bit missing);
            int key;
            key = y * 1024 + x;
            if (!store.exists(key)) begin
                missing = 1;
                return '0;
            end
            return store[key];
        endfunction

        function logic [7:0] blend(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                   logic [7:0] c3, longint fx, longint fy);
            longint top, bot;
            top = c0 * (256 - fx) + c1 * fx;
            bot = c3 * (256 - fx) + c2 * fx;
            return 8'((top * (256 - fy) + bot * fy) >> 16);
        endfunction

        // Computes the result of one item; a write updates the store unless dry.
        function t_pixel_res predict(bit cmd, int unsigned px, int unsigned py,
                                     logic [23:0] pix, bit dry, output bit missing);
            t_pixel_res res;
            int unsigned w, h, s, sw, sh, nx, ny, i, j;
            longint fx, fy;
            logic [23:0] p0, p1, p2, p3;
            bit rx, ry;
            w = eff_w();
            h = eff_h();
            s = (scale == 0) ? 1 : scale;
            missing = 0;
            res = '{8'd0, 8'd0, 8'd0, 1'b0};
            if (!cmd) begin
                if (px >= w || py >= h) res.status = 1;
                else if (!dry) store[py * 1024 + px] = pix;
                return res;
            end
            sw = (w * s + PERCENT - 1) / PERCENT;
            sh = (h * s + PERCENT - 1) / PERCENT;
            nx = px * PERCENT;
            ny = py * PERCENT;
            i = nx / s;
            j = ny / s;
            fx = longint'(nx % s) * 256 / s;
            fy = longint'(ny % s) * 256 / s;
            if (px >= sw || py >= sh || i >= w || j >= h) begin
                res.status = 1;
                return res;
            end
            rx = (i + 1 < w);
            ry = (j + 1 < h);
            p0 = fetch(i, j, missing);
            p1 = rx ? fetch(i + 1, j, missing) : p0;
            p3 = ry ? fetch(i, j + 1, missing) : p0;
            if (rx && ry) p2 = fetch(i + 1, j + 1, missing);
            else if (!rx) p2 = p3;
            else p2 = p1;
            res.blue  = blend(p0[7:0], p1[7:0], p2[7:0], p3[7:0], fx, fy);
            res.green = blend(p0[15:8], p1[15:8], p2[15:8], p3[15:8], fx, fy);
            res.red   = blend(p0[23:16], p1[23:16], p2[23:16], p3[23:16], fx, fy);
            return res;
        endfunction

        function void note_item(bit cmd, int unsigned px, int unsigned py, logic [23:0] pix);
            bit missing;
            t_pixel_res res;
            res = predict(cmd, px, py, pix, 0, missing);
            if (cmd && !res.status) n_reads++;
            if (res.status) n_errs++;
            expected_q.push_back(res);
        endfunction

        function void check_result(t_pixel_res got);
            t_pixel_res exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected: b=%0d g=%0d r=%0d st=%0d",
                         $realtime, got.blue, got.green, got.red, got.status);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got != exp_res) begin
                $display("%0t: mismatch expected b=%0d g=%0d r=%0d st=%0d, actual b=%0d g=%0d r=%0d st=%0d",
                         $realtime, exp_res.blue, exp_res.green, exp_res.red, exp_res.status,
                         got.blue, got.green, got.red, got.status);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cmd;
    logic [POS_W-1:0]   i_pos_x;
    logic [POS_W-1:0]   i_pos_y;
    logic [CLR_W-1:0]   i_in_blue;
    logic [CLR_W-1:0]   i_in_green;
    logic [CLR_W-1:0]   i_in_red;
    logic               o_strobe;
    logic [CLR_W-1:0]   o_out_blue;
    logic [CLR_W-1:0]   o_out_green;
    logic [CLR_W-1:0]   o_out_red;
    logic               o_status;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    t_cfg_idx           i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;

    pixel_scoreboard    sb;
    int                 cycle_count;
    bit                 no_gaps;

    bilinear_image_scaler u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_in_blue   (i_in_blue),
        .i_in_green  (i_in_green),
        .i_in_red    (i_in_red),
        .o_strobe    (o_strobe),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result('{o_out_blue, o_out_green, o_out_red, o_status});
    end

    task automatic send_item(bit cmd, int unsigned px, int unsigned py, logic [23:0] pix);
        int unsigned gap;
        gap = 0;
        if (!no_gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                          : $urandom_range(0, 2);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1;
        i_cmd      <= cmd;
        i_pos_x    <= POS_W'(px);
        i_pos_y    <= POS_W'(py);
        i_in_blue  <= pix[7:0];
        i_in_green <= pix[15:8];
        i_in_red   <= pix[23:16];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item(cmd, px, py, pix);
    endtask

    // Stops the item stream, drains every result and then lets the pipeline empty.
    task automatic wait_idle();
        start <= 0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        sb.set_reg(idx, data);
    endtask

    // Writes the top-left corner of the source image so that requests near it are defined.
    task automatic fill_corner(int unsigned cw, int unsigned ch);
        for (int unsigned y = 0; y < ch; y++)
            for (int unsigned x = 0; x < cw; x++)
                send_item(1'b0, x, y, 24'($urandom));
    endtask

    // Picks a request whose neighbours are all written, or one that is refused.
    task automatic send_request(int unsigned reach);
        int unsigned px, py;
        bit missing;
        t_pixel_res res;
        for (int tries = 0; tries < 30; tries++) begin
            if ($urandom_range(0, 15) == 0) begin
                px = $urandom_range(0, 4095);
                py = $urandom_range(0, 4095);
            end else begin
                px = $urandom_range(0, reach);
                py = $urandom_range(0, reach);
            end
            res = sb.predict(1'b1, px, py, '0, 1, missing);
            if (!missing) break;
            px = 0;
            py = 0;
        end
        send_item(1'b1, px, py, '0);
    endtask

    task automatic run_phase(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                             logic [CFG_W-1:0] s, int unsigned n_random);
        int unsigned cw, ch, reach;
        wait_idle();
        write_reg(CFG_SRC_W, w);
        write_reg(CFG_SRC_H, h);
        write_reg(CFG_SCALE, s);
        no_gaps = ($urandom_range(0, 3) == 0);
        cw = sb.eff_w() < 6 ? sb.eff_w() : 6;
        ch = sb.eff_h() < 6 ? sb.eff_h() : 6;
        fill_corner(cw, ch);
        reach = (cw + 2) * ((sb.scale == 0) ? 1 : sb.scale) / PERCENT + 2;
        for (int n = 0; n < n_random; n++) begin
            if ($urandom_range(0, 5) == 0) begin
                if ($urandom_range(0, 2) == 0)
                    send_item(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                              24'($urandom));
                else
                    send_item(1'b0, $urandom_range(0, cw - 1), $urandom_range(0, ch - 1),
                              24'($urandom));
            end else begin
                send_request(reach);
            end
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        cycle_count = 0;
        no_gaps     = 0;
        i_rst_n     = 0;
        start       = 0;
        i_cmd       = 0;
        i_pos_x     = '0;
        i_pos_y     = '0;
        i_in_blue   = '0;
        i_in_green  = '0;
        i_in_red    = '0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_SRC_W;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: default geometry, extreme colors and coordinates.
        send_item(1'b0, 0, 0, 24'h000000);
        send_item(1'b0, 1, 0, 24'hFFFFFF);
        send_item(1'b0, 0, 1, 24'hFF00FF);
        send_item(1'b0, 1, 1, 24'h00FF00);
        send_item(1'b0, 1023, 1023, 24'hA5A5A5);
        send_item(1'b0, 4095, 4095, 24'h5A5A5A);
        send_item(1'b0, 1024, 0, 24'h123456);
        send_item(1'b0, 0, 1024, 24'h654321);
        send_item(1'b1, 0, 0, '0);
        send_item(1'b1, 1023, 1023, '0);
        send_item(1'b1, 1024, 0, '0);
        send_item(1'b1, 0, 1024, '0);
        send_item(1'b1, 4095, 4095, '0);
        send_item(1'b1, 2730, 1365, '0);

        // Size and scale extremes, including out-of-range values that saturate.
        run_phase(11'd4, 11'd3, 11'd100, 50);
        run_phase(11'd0, 11'd0, 11'd0, 30);
        run_phase(11'd1, 11'd1, 11'd1, 30);
        run_phase(11'd5, 11'd7, 11'd400, 70);
        run_phase(11'd2047, 11'd6, 11'd37, 60);
        run_phase(11'd3, 11'd1024, 11'd511, 60);
        run_phase(11'd1024, 11'd1025, 11'd250, 60);
        run_phase(11'd2, 11'd2, 11'd150, 50);
        run_phase(11'($urandom_range(1, 8)), 11'($urandom_range(1, 8)),
                  11'($urandom_range(1, 400)), 60);
        run_phase(11'h555, 11'h2AA, 11'h6AB, 40);
        wait_idle();

        $display("Covered %0d interpolated pixels and %0d refused items over 11 geometries.",
                 sb.n_reads, sb.n_errs);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/bis_pkg.sv
rtl/bis_div.sv
rtl/bis_store.sv
rtl/bis_blend.sv
rtl/bilinear_image_scaler.sv
tb/tb_top.sv
